FILE: rtl/pimap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pimap_pkg: shared constants and types of the interrupt-map lookup
// Table geometry, command and status codes, register indexes and the records
// that pass between the control logic and the row of table cells.
// ----------------------------------------------------------------------------
package pimap_pkg;

  localparam int ENTRIES  = 32;
  localparam int INO_BITS = 6;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 5;
  localparam int WORD_W   = 32;
  localparam int BUS_W    = 8;
  localparam int DEV_W    = 5;
  localparam int FN_W     = 3;
  localparam int RPIN_W   = 8;
  localparam int STATUS_W = 2;
  localparam int IRQ_W    = 6;
  localparam int CFG_IDX_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_PIN   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_PIN    = 2'd3;

  // Input tdata layout, lowest bit first
  localparam int IN_IDX_LSB  = 0;
  localparam int IN_HIGH_LSB = IN_IDX_LSB + IDX_W;
  localparam int IN_MID_LSB  = IN_HIGH_LSB + WORD_W;
  localparam int IN_LOW_LSB  = IN_MID_LSB + WORD_W;
  localparam int IN_PIN_LSB  = IN_LOW_LSB + WORD_W;
  localparam int IN_PAR_LSB  = IN_PIN_LSB + WORD_W;
  localparam int IN_BUS_LSB  = IN_PAR_LSB + WORD_W;
  localparam int IN_DEV_LSB  = IN_BUS_LSB + BUS_W;
  localparam int IN_FN_LSB   = IN_DEV_LSB + DEV_W;
  localparam int IN_RPIN_LSB = IN_FN_LSB + FN_W;
  localparam int IN_USED_W   = IN_RPIN_LSB + RPIN_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((IRQ_W + 7) / 8) * 8;

  typedef struct packed {
    logic [WORD_W-1:0]   addr_high;
    logic [WORD_W-1:0]   addr_middle;
    logic [WORD_W-1:0]   addr_low;
    logic [WORD_W-1:0]   pin;
    logic [INO_BITS-1:0] ino;
  } entry_t;

  typedef struct packed {
    logic [WORD_W-1:0] high;
    logic [WORD_W-1:0] middle;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] pin;
  } mask_t;

  typedef struct packed {
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] pin;
  } request_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic                found;
    logic [INO_BITS-1:0] ino;
  } token_t;

  function automatic logic [IRQ_W-1:0] ino_to_irq(input logic [INO_BITS-1:0] ino);
    return IRQ_W'(ino);
  endfunction

endpackage

FILE: rtl/pimap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pimap_cell: one slot of the interrupt-map table
// Holds one entry and its valid bit, tests it against the broadcast request
// and forwards the search token to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module pimap_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic               clear_i,
  input  pimap_pkg::entry_t   entry_i,
  input  pimap_pkg::mask_t    mask_i,
  input  pimap_pkg::request_t req_i,
  input  pimap_pkg::token_t   tok_i,
  output pimap_pkg::token_t   tok_o,
  output logic               valid_o
);
  import pimap_pkg::*;

  entry_t entry_q;
  logic   valid_q;
  token_t tok_q, tok_d;
  logic   hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (wr_en_i) begin
      valid_q <= 1'b1;
    end
  end

  assign hit = valid_q
             && ((entry_q.addr_high & mask_i.high) == (req_i.addr & mask_i.high))
             && ((entry_q.addr_middle & mask_i.middle) == '0)
             && ((entry_q.addr_low & mask_i.low) == '0)
             && ((entry_q.pin & mask_i.pin) == (req_i.pin & mask_i.pin));

  // Take the token on the first hit; pass it on unchanged otherwise
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found && hit) begin
      tok_d.found = 1'b1;
      tok_d.ino   = entry_q.ino;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;

endmodule

FILE: rtl/pci_interrupt_map_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_interrupt_map_lookup_top: interrupt-map routing table with masked lookup
// Stores routing entries in a row of cells and resolves a PCI function and
// pin to a parent interrupt number by passing a search token down the row.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Contents
// s_axis    in   tvalid/tready        tuser: command; tdata: entry and lookup
// m_axis    out  tvalid/tready        tuser: status; tdata: interrupt number
// cfg       in   cfg_wr_en_i          register index and write data, no wait
//
// Write, clear, unused commands and lookups with pin zero answer straight from the accept, without a scan.
// A lookup result passes, after its accept, through the launch register, one
// register per cell as the token walks the row, the register that parks the
// result and the output register; the row length sets its delay.
// Reset clears all valid bits and the masks to their defaults at once; no
// sweep is needed. A stalled output holds its result and blocks new input
// until it is taken, but an input is taken in the cycle the output drains.
//
module pci_interrupt_map_lookup_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tuser: [1:0] command
  // tdata: [4:0] entry_index, [36:5] entry_address_high,
  //        [68:37] entry_address_middle, [100:69] entry_address_low,
  //        [132:101] entry_pin, [164:133] entry_parent_interrupt,
  //        [172:165] bus_number, [177:173] device_number,
  //        [180:178] function_number, [188:181] request_pin, [191:189] zero
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pimap_pkg::CMD_W-1:0]          s_axis_tuser,
  input  logic [pimap_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: [1:0] status
  // tdata: [5:0] interrupt_number, [7:6] zero
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pimap_pkg::STATUS_W-1:0]       m_axis_tuser,
  output logic [pimap_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_wr_en_i,
  input  logic [pimap_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pimap_pkg::WORD_W-1:0]         cfg_wdata_i
);
  import pimap_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;

  mask_t    mask_q;
  request_t req_q;
  logic     launch_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [IRQ_W-1:0]    out_irq_q;
  logic [STATUS_W-1:0] hold_status_q;
  logic [IRQ_W-1:0]    hold_irq_q;

  logic                out_free;
  logic                in_fire;
  logic [CMD_W-1:0]    cmd;
  logic [IDX_W-1:0]    in_idx;
  logic [RPIN_W-1:0]   in_rpin;
  logic                start_scan;
  logic                imm_load;
  logic [STATUS_W-1:0] imm_status;
  entry_t              wr_entry;
  logic                tbl_wr;
  logic                tbl_clr;

  token_t              tok_chain [ENTRIES+1];
  logic [ENTRIES-1:0]  tok_valid_vec;
  logic [ENTRIES-1:0]  cell_valid;
  token_t              tail;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q.high   <= 32'h00ff_f800;
      mask_q.middle <= '0;
      mask_q.low    <= '0;
      mask_q.pin    <= 32'h0000_0007;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_index_i)
        REG_MASK_HIGH:   mask_q.high   <= cfg_wdata_i;
        REG_MASK_MIDDLE: mask_q.middle <= cfg_wdata_i;
        REG_MASK_LOW:    mask_q.low    <= cfg_wdata_i;
        REG_MASK_PIN:    mask_q.pin    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cmd           = s_axis_tuser;
  assign in_idx        = s_axis_tdata[IN_IDX_LSB +: IDX_W];
  assign in_rpin       = s_axis_tdata[IN_RPIN_LSB +: RPIN_W];

  assign wr_entry.addr_high   = s_axis_tdata[IN_HIGH_LSB +: WORD_W];
  assign wr_entry.addr_middle = s_axis_tdata[IN_MID_LSB +: WORD_W];
  assign wr_entry.addr_low    = s_axis_tdata[IN_LOW_LSB +: WORD_W];
  assign wr_entry.pin         = s_axis_tdata[IN_PIN_LSB +: WORD_W];
  assign wr_entry.ino         = s_axis_tdata[IN_PAR_LSB +: INO_BITS];

  assign tbl_wr  = in_fire && (cmd == CMD_WRITE);
  assign tbl_clr = in_fire && (cmd == CMD_CLEAR);

  // Everything except a real lookup loads its answer into the output register on accept
  assign start_scan = in_fire && (cmd == CMD_LOOKUP) && (in_rpin != '0);
  assign imm_load   = in_fire && !start_scan;
  assign imm_status = ((cmd == CMD_LOOKUP) && (in_rpin == '0)) ? ST_BAD_PIN : ST_OK;

  // Capture the request; the token enters cell 0 in the following cycle
  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      req_q.addr <= {8'h00,
                     s_axis_tdata[IN_BUS_LSB +: BUS_W],
                     s_axis_tdata[IN_DEV_LSB +: DEV_W],
                     s_axis_tdata[IN_FN_LSB +: FN_W],
                     8'h00};
      req_q.pin  <= WORD_W'(in_rpin);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
    end else begin
      launch_q <= start_scan;
    end
  end

  // --------------------------------------------------------------------------
  // Row of table cells
  // --------------------------------------------------------------------------
  assign tok_chain[0].valid = launch_q;
  assign tok_chain[0].found = 1'b0;
  assign tok_chain[0].ino   = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic sel;
    assign sel = tbl_wr && (int'(in_idx) == i);

    pimap_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_en_i (sel),
      .clear_i (tbl_clr),
      .entry_i (wr_entry),
      .mask_i  (mask_q),
      .req_i   (req_q),
      .tok_i   (tok_chain[i]),
      .tok_o   (tok_chain[i+1]),
      .valid_o (cell_valid[i])
    );

    assign tok_valid_vec[i] = tok_chain[i+1].valid;
  end

  assign tail = tok_chain[ENTRIES];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start_scan) state_d = S_SCAN;
      S_SCAN:  if (tail.valid) state_d = S_DRAIN;
      S_DRAIN: if (out_free)   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Park the token result until the output register frees up
  always_ff @(posedge clk_i) begin
    if ((state_q == S_SCAN) && tail.valid) begin
      hold_status_q <= tail.found ? ST_OK : ST_NOT_FOUND;
      hold_irq_q    <= tail.found ? ino_to_irq(tail.ino) : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (imm_load || ((state_q == S_DRAIN) && out_free)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (imm_load) begin
      out_status_q <= imm_status;
      out_irq_q    <= '0;
    end else if ((state_q == S_DRAIN) && out_free) begin
      out_status_q <= hold_status_q;
      out_irq_q    <= hold_irq_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_irq_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Only one search token may be in the row at a time
  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({launch_q, tok_valid_vec}))
    else $error("more than one search token in the cell row");

  // The token leaves the row only while the sequencer waits for it
  a_tail_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> (state_q == S_SCAN))
    else $error("search token left the row outside a scan");

  // A clear leaves no valid entry behind
  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_clr |=> (cell_valid == '0))
    else $error("valid entries remain after a clear");

  // A failed result carries a zero interrupt number
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
    else $error("nonzero interrupt number on a failed lookup");

endmodule
